// ===== design/par_pkg.sv =====
// Shared types and constants for the polyphase audio resampler.
// Used by every module of the block; it depends on nothing else.
package par_pkg;

    localparam int MAX_TAPS     = 32;
    localparam int TAP_W        = 5;
    localparam int MAX_PHASES   = 1024;
    localparam int ROW_W        = 11;
    localparam int MAX_RUN      = 64;
    localparam int RUN_W        = 7;
    localparam int BANK_DEPTH   = (MAX_PHASES + 1) * MAX_TAPS;
    localparam int ADDR_W       = 16;
    localparam int FILTER_SHIFT = 15;
    localparam int ACC_W        = 37;
    localparam int VAL_W        = 38;
    localparam int PH_W         = 17;
    localparam int DIV_W        = 68;
    localparam int REM_W        = 32;
    localparam int CNT_W        = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [ACC_W-1:0] ROUND_OFFSET = ACC_W'(1 << (FILTER_SHIFT - 1));

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WHOLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FRACTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MODE   = 3'd5;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_COEF,
        KIND_DROP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] sample;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] coef;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_WRAP,
        S_MAC,
        S_MUL,
        S_DIV,
        S_RESULT,
        S_FLUSH
    } state_t;

endpackage

// ===== design/par_item_if.sv =====
// Input item channel of the resampler: handshake plus sample and coefficient fields.
// Depends on nothing.
interface par_item_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] sample_value;
    logic [15:0]        coef_address;
    logic signed [15:0] coef_value;

    modport source (output valid, command, sample_value, coef_address, coef_value,
                    input ready);
    modport sink (input valid, command, sample_value, coef_address, coef_value,
                  output ready);
endinterface

// ===== design/par_result_if.sv =====
// Result channel of the resampler: handshake plus output sample and run end flag.
// Depends on nothing.
interface par_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               run_end;

    modport source (output valid, out_sample, run_end, input ready);
    modport sink (input valid, out_sample, run_end, output ready);
endinterface

// ===== design/par_cfg_if.sv =====
// Configuration write channel of the resampler: handshake, register index and data.
// Depends on nothing.
interface par_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/par_front.sv =====
// Front end: accepts input beats and classifies them for the back end.
// Depends on par_pkg and par_item_if.
module par_front (
    par_item_if.sink          items,
    input  par_pkg::q_status_t q_status,
    output logic              push,
    output par_pkg::item_t    push_item
);

    assign items.ready = !q_status.full;
    assign push        = items.valid && !q_status.full;

    always_comb
    begin
        push_item.sample = items.sample_value;
        push_item.addr   = items.coef_address;
        push_item.coef   = items.coef_value;
        if (!items.command)
        begin
            push_item.kind = par_pkg::KIND_SAMPLE;
        end
        else if (items.coef_address < 16'(par_pkg::BANK_DEPTH))
        begin
            push_item.kind = par_pkg::KIND_COEF;
        end
        else
        begin
            push_item.kind = par_pkg::KIND_DROP;
        end
    end

endmodule

// ===== design/par_queue.sv =====
// Two-entry queue between the front and back ends of the resampler.
// Depends on par_pkg.
module par_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  par_pkg::item_t     push_item,
    input  logic               pop,
    output par_pkg::item_t     pop_item,
    output par_pkg::q_status_t status
);

    par_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign pop_item     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/par_back.sv =====
// Back end: configuration registers, coefficient memory, tap history, serial MAC,
// interpolation and phase stepping. Depends on par_pkg, par_cfg_if and par_result_if.
module par_back (
    input  logic               clk,
    input  logic               rst_n,
    input  par_pkg::q_status_t q_status,
    input  par_pkg::item_t     q_item,
    output logic               pop,
    par_cfg_if.sink            cfg,
    par_result_if.source       results
);

    par_pkg::state_t state_reg, state_next;

    logic [10:0] phase_total_reg;
    logic [5:0]  tap_count_reg;
    logic [15:0] step_whole_reg;
    logic [30:0] step_fraction_reg;
    logic [30:0] fraction_base_reg;
    logic        linear_mode_reg;

    logic [15:0] bank [par_pkg::BANK_DEPTH];
    logic signed [15:0] mem_q_reg;
    logic [15:0] hist_reg [par_pkg::MAX_TAPS];

    logic [5:0]  fill_reg;
    logic [par_pkg::PH_W-1:0] phase_reg;
    logic [30:0] rem_reg;
    logic [15:0] pend_reg;
    logic [par_pkg::RUN_W-1:0] run_cnt_reg;
    logic        held_valid_reg;
    logic [15:0] held_reg;
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic        out_end_reg;

    logic [5:0]  issue_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic signed [15:0] h1_reg;
    logic signed [31:0] prod_reg;
    logic signed [par_pkg::ACC_W-1:0] acc_reg;
    logic        second_reg;
    logic [par_pkg::ROW_W-1:0] row_reg;
    logic signed [par_pkg::VAL_W-1:0] val_reg;

    logic        neg_reg;
    logic [par_pkg::ACC_W-1:0] ud_reg;
    logic [30:0] fr_reg;
    logic [par_pkg::CNT_W-1:0] bitcnt_reg;
    logic [par_pkg::DIV_W-1:0] mp_reg;

    logic [par_pkg::DIV_W-1:0] dq_reg;
    logic [par_pkg::REM_W-1:0] drem_reg;
    logic [30:0] divisor_reg;
    logic [par_pkg::CNT_W-1:0] dcnt_reg;

    logic [10:0] pt_eff;
    logic [5:0]  taps_eff;
    logic [30:0] base_eff;
    logic        out_free;
    logic [5:0]  fill_new;
    logic        is_sample;
    logic        is_coef;
    logic        mac_done;
    logic [par_pkg::TAP_W-1:0] rd_tap;
    logic [par_pkg::ADDR_W-1:0] rd_addr;
    logic [par_pkg::REM_W-1:0] div_trial;
    logic        div_bit;
    logic signed [par_pkg::VAL_W-1:0] acc_ext;
    logic signed [par_pkg::VAL_W-1:0] diff;
    logic signed [par_pkg::VAL_W-1:0] q_ext;
    logic signed [par_pkg::VAL_W-1:0] shifted;
    logic [15:0] sat_val;
    logic [31:0] rem_sum;
    logic        rem_carry;

    always_comb
    begin
        if (phase_total_reg == 11'd0)
        begin
            pt_eff = 11'd1;
        end
        else if (phase_total_reg > 11'(par_pkg::MAX_PHASES))
        begin
            pt_eff = 11'(par_pkg::MAX_PHASES);
        end
        else
        begin
            pt_eff = phase_total_reg;
        end
        if (tap_count_reg == 6'd0)
        begin
            taps_eff = 6'd1;
        end
        else if (tap_count_reg > 6'(par_pkg::MAX_TAPS))
        begin
            taps_eff = 6'(par_pkg::MAX_TAPS);
        end
        else
        begin
            taps_eff = tap_count_reg;
        end
        base_eff = (fraction_base_reg == 31'd0) ? 31'd1 : fraction_base_reg;
    end

    assign out_free  = !out_valid_reg || results.ready;
    assign fill_new  = (fill_reg == 6'(par_pkg::MAX_TAPS)) ? fill_reg : fill_reg + 6'd1;
    assign is_sample = (q_item.kind == par_pkg::KIND_SAMPLE);
    assign is_coef   = (q_item.kind == par_pkg::KIND_COEF);
    assign mac_done  = (issue_reg == taps_eff) && !v1_reg && !v2_reg;
    assign rd_tap    = 5'(6'(par_pkg::MAX_TAPS) - taps_eff) + issue_reg[par_pkg::TAP_W-1:0];
    assign rd_addr   = {row_reg, issue_reg[par_pkg::TAP_W-1:0]};

    assign div_trial = {drem_reg[30:0], dq_reg[par_pkg::DIV_W-1]};
    assign div_bit   = (div_trial >= {1'b0, divisor_reg});

    assign acc_ext = {acc_reg[par_pkg::ACC_W-1], acc_reg};
    assign diff    = acc_ext - val_reg;
    assign q_ext   = {1'b0, dq_reg[par_pkg::ACC_W-1:0]};
    assign shifted = val_reg >>> par_pkg::FILTER_SHIFT;

    always_comb
    begin
        if (shifted > 38'sd32767)
        begin
            sat_val = 16'h7FFF;
        end
        else if (shifted < -38'sd32768)
        begin
            sat_val = 16'h8000;
        end
        else
        begin
            sat_val = shifted[15:0];
        end
    end

    assign rem_sum   = {1'b0, rem_reg} + {1'b0, step_fraction_reg};
    assign rem_carry = (rem_sum >= {1'b0, base_eff});

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            par_pkg::S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (is_sample && fill_new >= taps_eff && pend_reg <= 16'd1)
                    begin
                        state_next = par_pkg::S_TOP;
                    end
                end
            end
            par_pkg::S_TOP:
            begin
                if (phase_reg >= {6'd0, pt_eff})
                begin
                    state_next = par_pkg::S_WRAP;
                end
                else if (run_cnt_reg == 7'(par_pkg::MAX_RUN))
                begin
                    state_next = par_pkg::S_FLUSH;
                end
                else
                begin
                    state_next = par_pkg::S_MAC;
                end
            end
            par_pkg::S_WRAP:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = par_pkg::S_FLUSH;
                end
            end
            par_pkg::S_MAC:
            begin
                if (mac_done)
                begin
                    if (!linear_mode_reg)
                    begin
                        state_next = par_pkg::S_RESULT;
                    end
                    else if (second_reg)
                    begin
                        state_next = par_pkg::S_MUL;
                    end
                end
            end
            par_pkg::S_MUL:
            begin
                if (bitcnt_reg == '0)
                begin
                    state_next = par_pkg::S_DIV;
                end
            end
            par_pkg::S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = par_pkg::S_RESULT;
                end
            end
            par_pkg::S_RESULT:
            begin
                if (!held_valid_reg || out_free)
                begin
                    state_next = par_pkg::S_TOP;
                end
            end
            par_pkg::S_FLUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    state_next = par_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = par_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= par_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_total_reg   <= 11'd1;
            tap_count_reg     <= 6'd1;
            step_whole_reg    <= 16'd1;
            step_fraction_reg <= 31'd0;
            fraction_base_reg <= 31'd1;
            linear_mode_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                par_pkg::REG_PHASE_TOTAL:   phase_total_reg   <= cfg.data[10:0];
                par_pkg::REG_TAP_COUNT:     tap_count_reg     <= cfg.data[5:0];
                par_pkg::REG_STEP_WHOLE:    step_whole_reg    <= cfg.data[15:0];
                par_pkg::REG_STEP_FRACTION: step_fraction_reg <= cfg.data[30:0];
                par_pkg::REG_FRACTION_BASE: fraction_base_reg <= cfg.data[30:0];
                par_pkg::REG_LINEAR_MODE:   linear_mode_reg   <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == par_pkg::S_IDLE && pop && is_coef)
        begin
            bank[q_item.addr] <= q_item.coef;
        end
        mem_q_reg <= bank[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < par_pkg::MAX_TAPS; k++)
            begin
                hist_reg[k] <= 16'd0;
            end
        end
        else if (state_reg == par_pkg::S_IDLE && pop && is_sample)
        begin
            for (int k = 0; k < par_pkg::MAX_TAPS - 1; k++)
            begin
                hist_reg[k] <= hist_reg[k + 1];
            end
            hist_reg[par_pkg::MAX_TAPS - 1] <= q_item.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= 6'd0;
            phase_reg      <= '0;
            rem_reg        <= 31'd0;
            pend_reg       <= 16'd0;
            run_cnt_reg    <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            issue_reg      <= 6'd0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            second_reg     <= 1'b0;
            bitcnt_reg     <= '0;
            dcnt_reg       <= '0;
        end
        else
        begin
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                par_pkg::S_IDLE:
                begin
                    run_cnt_reg    <= '0;
                    held_valid_reg <= 1'b0;
                    if (pop && is_sample)
                    begin
                        fill_reg <= fill_new;
                        if (fill_new >= taps_eff && pend_reg != 16'd0)
                        begin
                            pend_reg <= pend_reg - 16'd1;
                        end
                    end
                end
                par_pkg::S_TOP:
                begin
                    if (phase_reg >= {6'd0, pt_eff})
                    begin
                        dq_reg      <= {phase_reg, (par_pkg::DIV_W - par_pkg::PH_W)'(0)};
                        drem_reg    <= '0;
                        divisor_reg <= {20'd0, pt_eff};
                        dcnt_reg    <= 7'(par_pkg::PH_W);
                    end
                    else
                    begin
                        row_reg    <= phase_reg[par_pkg::ROW_W-1:0];
                        second_reg <= 1'b0;
                        issue_reg  <= 6'd0;
                        v1_reg     <= 1'b0;
                        v2_reg     <= 1'b0;
                        acc_reg    <= par_pkg::ROUND_OFFSET;
                    end
                end
                par_pkg::S_WRAP:
                begin
                    if (dcnt_reg != '0)
                    begin
                        drem_reg <= div_bit ? div_trial - {1'b0, divisor_reg} : div_trial;
                        dq_reg   <= {dq_reg[par_pkg::DIV_W-2:0], div_bit};
                        dcnt_reg <= dcnt_reg - 7'd1;
                    end
                    else
                    begin
                        phase_reg <= {6'd0, drem_reg[10:0]};
                        pend_reg  <= (dq_reg[16] ? 16'hFFFF : dq_reg[15:0]);
                    end
                end
                par_pkg::S_MAC:
                begin
                    if (issue_reg != taps_eff)
                    begin
                        h1_reg    <= hist_reg[rd_tap];
                        v1_reg    <= 1'b1;
                        issue_reg <= issue_reg + 6'd1;
                    end
                    else
                    begin
                        v1_reg <= 1'b0;
                    end
                    v2_reg <= v1_reg;
                    if (v1_reg)
                    begin
                        prod_reg <= h1_reg * mem_q_reg;
                    end
                    if (v2_reg)
                    begin
                        acc_reg <= acc_reg + {{5{prod_reg[31]}}, prod_reg};
                    end
                    if (mac_done)
                    begin
                        if (!linear_mode_reg || !second_reg)
                        begin
                            val_reg <= acc_ext;
                        end
                        if (linear_mode_reg && !second_reg)
                        begin
                            second_reg <= 1'b1;
                            row_reg    <= row_reg + 11'd1;
                            issue_reg  <= 6'd0;
                            acc_reg    <= par_pkg::ROUND_OFFSET;
                        end
                        if (linear_mode_reg && second_reg)
                        begin
                            neg_reg    <= diff[par_pkg::VAL_W-1];
                            ud_reg     <= diff[par_pkg::VAL_W-1] ? 37'(-diff) : 37'(diff);
                            fr_reg     <= (rem_reg > base_eff) ? base_eff : rem_reg;
                            mp_reg     <= '0;
                            bitcnt_reg <= 7'd31;
                        end
                    end
                end
                par_pkg::S_MUL:
                begin
                    if (bitcnt_reg != '0)
                    begin
                        mp_reg <= {mp_reg[par_pkg::DIV_W-2:0], 1'b0}
                                  + (fr_reg[30] ? {31'd0, ud_reg} : '0);
                        fr_reg     <= {fr_reg[29:0], 1'b0};
                        bitcnt_reg <= bitcnt_reg - 7'd1;
                    end
                    else
                    begin
                        dq_reg      <= mp_reg;
                        drem_reg    <= '0;
                        divisor_reg <= base_eff;
                        dcnt_reg    <= 7'(par_pkg::DIV_W);
                    end
                end
                par_pkg::S_DIV:
                begin
                    if (dcnt_reg != '0)
                    begin
                        drem_reg <= div_bit ? div_trial - {1'b0, divisor_reg} : div_trial;
                        dq_reg   <= {dq_reg[par_pkg::DIV_W-2:0], div_bit};
                        dcnt_reg <= dcnt_reg - 7'd1;
                    end
                    else
                    begin
                        val_reg <= neg_reg ? val_reg - q_ext : val_reg + q_ext;
                    end
                end
                par_pkg::S_RESULT:
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_sample_reg <= held_reg;
                            out_end_reg    <= 1'b0;
                        end
                        held_reg       <= sat_val;
                        held_valid_reg <= 1'b1;
                        run_cnt_reg    <= run_cnt_reg + 7'd1;
                        phase_reg      <= phase_reg + {1'b0, step_whole_reg}
                                          + {16'd0, rem_carry};
                        rem_reg        <= rem_carry ? 31'(rem_sum - {1'b0, base_eff})
                                                    : rem_sum[30:0];
                    end
                end
                par_pkg::S_FLUSH:
                begin
                    if (held_valid_reg && out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= held_reg;
                        out_end_reg    <= 1'b1;
                        held_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_sample_reg;
    assign results.run_end    = out_end_reg;

endmodule

// ===== design/polyphase_audio_resampler.sv =====
// Top level of the polyphase audio resampler: front end, item queue and back end.
// Depends on par_pkg, the three channel interfaces, par_front, par_queue and par_back.
//
// Items arrive on the items channel: a coefficient beat whose address lies in the bank
// writes one entry of it, a sample beat shifts the tap history and may start a run of
// up to 64 results on the results channel; the last result of a run has run_end set.
// Registers are written on the cfg channel, which is always ready; the user must write
// them only while the block is idle, which the block itself does not enforce. Each
// result takes one pass through the shared MAC; in linear mode two MAC passes plus
// the serial multiply and the 68-step divider. A phase wrap uses the same divider.
// A two-entry queue lets the input keep flowing while the back end works, until it
// fills. Reset clears the history and the phase state and sets the registers to
// their defaults; the coefficient bank holds no reset value and must be written
// before use. When the receiver stalls, one result waits in the output register
// and one more is held; the back end then waits until the output register frees.
module polyphase_audio_resampler (
    input  logic          clk,
    input  logic          rst_n,
    par_item_if.sink      items,
    par_result_if.source  results,
    par_cfg_if.sink       cfg
);

    par_pkg::q_status_t q_status;
    par_pkg::item_t     push_item;
    par_pkg::item_t     pop_item;
    logic               push;
    logic               pop;

    par_front u_front (
        .items     (items),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    par_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    par_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_item   (pop_item),
        .pop      (pop),
        .cfg      (cfg),
        .results  (results)
    );

endmodule

// ===== tb/sv/polyphase_audio_resampler_test.sv =====
// Self-checking testbench for polyphase_audio_resampler: a predictor of the filter, phase
// and window state checks every result beat in order while idling and stalls vary by phase.
// Depends on par_pkg, the par_item_if, par_result_if and par_cfg_if interfaces and the RTL.
module polyphase_audio_resampler_test;
    import par_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [15:0] pcm;
        logic               last;
    } out_beat_t;

    logic clk;
    logic rst_n;

    par_item_if   items_ch ();
    par_result_if results_ch ();
    par_cfg_if    cfg_ch ();

    polyphase_audio_resampler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state.
    logic [10:0]        phase_total_reg;
    logic [5:0]         tap_count_reg;
    logic [15:0]        step_whole_reg;
    logic [30:0]        step_fraction_reg;
    logic [30:0]        fraction_base_reg;
    logic               linear_reg;
    logic signed [15:0] history [MAX_TAPS];
    logic signed [15:0] bank [BANK_DEPTH];
    bit                 bank_known [BANK_DEPTH];
    int unsigned        phase_pos;
    longint unsigned    phase_rem;
    int unsigned        advance_pending;
    int unsigned        fill_level;

    out_beat_t expected_pcm [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int error_count;
    int items_sent;
    int beats_checked;
    int runs_seen;
    int config_writes;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #30_000_000;
        $display("polyphase_audio_resampler_test: done, errors");
        $finish;
    end

    task automatic report(input string what, input int exp_v, input int act_v);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
    endtask

    // Result side: random stalls, a long hold-off on request, and the in-order check.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_pcm.size() == 0)
                report("unexpected result beat", 0, results_ch.out_sample);
            else
            begin
                want = expected_pcm.pop_front();
                if (results_ch.out_sample !== want.pcm)
                    report("out_sample", want.pcm, results_ch.out_sample);
                if (results_ch.run_end !== want.last)
                    report("run_end", want.last, results_ch.run_end);
                beats_checked++;
                if (want.last)
                    runs_seen++;
            end
        end
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            results_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            results_ch.ready <= 1'b0;
        end
        else
            results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned eff_phases();
        if (phase_total_reg == 0)
            return 1;
        return (phase_total_reg > MAX_PHASES) ? MAX_PHASES : phase_total_reg;
    endfunction

    function automatic int unsigned eff_taps();
        if (tap_count_reg == 0)
            return 1;
        return (tap_count_reg > MAX_TAPS) ? MAX_TAPS : tap_count_reg;
    endfunction

    function automatic longint row_sum(input int unsigned row, input int unsigned taps);
        longint acc;
        acc = longint'(1) << (FILTER_SHIFT - 1);
        for (int i = 0; i < taps; i++)
            acc += longint'(history[MAX_TAPS - taps + i]) * longint'(bank[row * MAX_TAPS + i]);
        return acc;
    endfunction

    function automatic logic signed [15:0] shift_saturate(input longint v);
        longint r;
        r = v >>> FILTER_SHIFT;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic predict_item(input logic cmd, input logic signed [15:0] pcm,
                                input logic [15:0] addr, input logic signed [15:0] coef);
        int unsigned     pt;
        int unsigned     taps;
        longint unsigned base;
        longint unsigned fr;
        longint unsigned ud;
        longint unsigned q;
        longint          val;
        longint          d;
        int unsigned     wraps;
        int              n;
        out_beat_t       beat;
        pt = eff_phases();
        taps = eff_taps();
        base = (fraction_base_reg == 0) ? 1 : fraction_base_reg;
        n = 0;
        if (cmd)
        begin
            if (addr < BANK_DEPTH)
            begin
                bank[addr] = coef;
                bank_known[addr] = 1'b1;
            end
            return;
        end
        for (int i = 0; i < MAX_TAPS - 1; i++)
            history[i] = history[i + 1];
        history[MAX_TAPS - 1] = pcm;
        if (fill_level < MAX_TAPS)
            fill_level++;
        if (fill_level < taps)
            return;
        if (advance_pending > 0)
        begin
            advance_pending--;
            if (advance_pending > 0)
                return;
        end
        forever
        begin
            if (phase_pos >= pt)
            begin
                wraps = phase_pos / pt;
                phase_pos = phase_pos % pt;
                advance_pending = (wraps > 65535) ? 65535 : wraps;
                break;
            end
            if (n >= MAX_RUN)
                break;
            val = row_sum(phase_pos, taps);
            if (linear_reg)
            begin
                d = row_sum(phase_pos + 1, taps) - val;
                fr = (phase_rem > base) ? base : phase_rem;
                ud = (d < 0) ? longint'(-d) : longint'(d);
                q = (ud / base) * fr + ((ud % base) * fr) / base;
                val = (d < 0) ? val - longint'(q) : val + longint'(q);
            end
            beat.pcm = shift_saturate(val);
            beat.last = 1'b0;
            expected_pcm.push_back(beat);
            n++;
            phase_pos += step_whole_reg;
            phase_rem += step_fraction_reg;
            if (phase_rem >= base)
            begin
                phase_rem -= base;
                phase_pos++;
            end
            phase_rem &= 64'h7FFF_FFFF;
        end
        if (n > 0)
            expected_pcm[$].last = 1'b1;
    endtask

    task automatic send_item(input logic cmd, input logic signed [15:0] pcm,
                             input logic [15:0] addr, input logic signed [15:0] coef);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid        <= 1'b1;
        items_ch.command      <= cmd;
        items_ch.sample_value <= pcm;
        items_ch.coef_address <= addr;
        items_ch.coef_value   <= coef;
        do
            @(posedge clk);
        while (!items_ch.ready);
        predict_item(cmd, pcm, addr, coef);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [15:0] pcm);
        send_item(1'b0, pcm, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(input logic [15:0] addr, input logic signed [15:0] coef);
        send_item(1'b1, 16'($urandom), addr, coef);
    endtask

    task automatic drain_and_settle();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pcm.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PHASE_TOTAL:   phase_total_reg = value[10:0];
            REG_TAP_COUNT:     tap_count_reg = value[5:0];
            REG_STEP_WHOLE:    step_whole_reg = value[15:0];
            REG_STEP_FRACTION: step_fraction_reg = value[30:0];
            REG_FRACTION_BASE: fraction_base_reg = value[30:0];
            REG_LINEAR_MODE:   linear_reg = value[0];
            default: ;
        endcase
        config_writes++;
    endtask

    // Writes every coefficient the current setting can read that was never written.
    task automatic fill_bank_rows();
        int unsigned pt;
        int unsigned taps;
        pt = eff_phases();
        taps = eff_taps();
        for (int unsigned row = 0; row <= pt; row++)
            for (int unsigned col = 0; col < taps; col++)
                if (!bank_known[row * MAX_TAPS + col])
                    send_coef(16'(row * MAX_TAPS + col), 16'($urandom));
    endtask

    task automatic configure(input int unsigned pt, input int unsigned taps,
                             input int unsigned whole, input int unsigned frac,
                             input int unsigned base, input bit lin);
        write_reg(REG_PHASE_TOTAL, pt);
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_STEP_WHOLE, whole);
        write_reg(REG_STEP_FRACTION, frac);
        write_reg(REG_FRACTION_BASE, base);
        write_reg(REG_LINEAR_MODE, lin);
        fill_bank_rows();
    endtask

    function automatic logic signed [15:0] random_pcm();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_register_extremes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        configure(0, 63, 0, 0, 0, 1'b0);
        for (int i = 0; i < 33; i++)
            send_sample(random_pcm());
        drain_and_settle();
    endtask

    task automatic test_directed();
        configure(4, 4, 1, 1, 3, 1'b1);
        send_coef(16'd0, 16'sh7FFF);
        send_coef(16'd1, 16'sh7FFF);
        send_coef(16'(MAX_TAPS), 16'sh8000);
        send_coef(16'(MAX_TAPS + 3), 16'sh8000);
        send_coef(16'(BANK_DEPTH), 16'sh1234);
        send_coef(16'hFFFF, 16'sh8000);
        for (int i = 0; i < 4; i++)
            send_sample(16'sh7FFF);
        for (int i = 0; i < 4; i++)
            send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        drain_and_settle();
    endtask

    task automatic test_fraction_extremes();
        configure(2047, 0, 0, 2147483646, 2147483647, 1'b1);
        for (int i = 0; i < 3; i++)
            send_sample(random_pcm());
        drain_and_settle();
    endtask

    task automatic random_setting();
        int unsigned pt;
        int unsigned base;
        pt = ($urandom_range(5) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        if (phase_pos / pt > 3)
            pt = phase_pos / 3 + 1;
        if (pt > MAX_PHASES)
            pt = MAX_PHASES;
        base = $urandom_range(1) ? $urandom_range(1, 1000) : $urandom_range(1, 32'h7FFF_FFFF);
        configure(pt, ($urandom_range(2) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6),
                  $urandom_range(1, pt), $urandom_range(0, base - 1), base, $urandom_range(1));
    endtask

    task automatic random_items(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_sample(random_pcm());
            else if (pick < 90)
                send_coef(16'($urandom_range(eff_phases()) * MAX_TAPS
                              + $urandom_range(eff_taps() - 1)), 16'($urandom));
            else
                send_coef(16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_phases();
        int idle_table [4] = '{0, 53, 0, 23};
        int stall_table [4] = '{0, 0, 53, 23};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_table[p];
            recv_stall_pct = stall_table[p];
            for (int k = 0; k < 2; k++)
            begin
                random_setting();
                random_items(30);
                drain_and_settle();
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(2, 3, 0, 1, 4, 1'b0);
        hold_requests++;
        random_items(30);
        drain_and_settle();
    endtask

    task automatic test_advance_saturation();
        int guard;
        configure(1, 1, 65535, 1, 1, 1'b0);
        guard = 0;
        while (advance_pending != 65535 && guard < 200)
        begin
            send_sample(random_pcm());
            guard++;
        end
        for (int i = 0; i < 3; i++)
            send_sample(random_pcm());
        drain_and_settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.command = 1'b0;
        items_ch.sample_value = '0;
        items_ch.coef_address = '0;
        items_ch.coef_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        results_ch.ready = 1'b0;
        phase_total_reg = 1;
        tap_count_reg = 1;
        step_whole_reg = 1;
        step_fraction_reg = 0;
        fraction_base_reg = 1;
        linear_reg = 1'b0;
        foreach (history[i])
            history[i] = '0;
        foreach (bank[i])
        begin
            bank[i] = '0;
            bank_known[i] = 1'b0;
        end
        phase_pos = 0;
        phase_rem = 0;
        advance_pending = 0;
        fill_level = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        error_count = 0;
        items_sent = 0;
        beats_checked = 0;
        runs_seen = 0;
        config_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_extremes();
        test_directed();
        test_fraction_extremes();
        test_random_phases();
        test_output_backpressure();
        test_advance_saturation();

        if (expected_pcm.size() > 0)
            report("results never delivered", expected_pcm.size(), 0);
        $display("Sent %0d items and %0d register writes; checked %0d output beats in %0d runs.",
                 items_sent, config_writes, beats_checked, runs_seen);
        $display("Covered clamped registers, run cap, linear mode, long stall and saturated advance.");
        if (error_count == 0)
            $display("polyphase_audio_resampler_test: done, clean");
        else
            $display("polyphase_audio_resampler_test: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
design/par_pkg.sv
design/par_item_if.sv
design/par_result_if.sv
design/par_cfg_if.sv
design/par_front.sv
design/par_queue.sv
design/par_back.sv
design/polyphase_audio_resampler.sv
tb/sv/polyphase_audio_resampler_test.sv
